/* design/lsh_pkg.sv */
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared constants, types and codes of the latency statistics histogram block.
// ----------------------------------------------------------------------------
package lsh_pkg;

    localparam int NUM_REGION_SETS = 8;
    localparam int NUM_FIXED_SETS  = 4;
    localparam int NUM_BUCKETS     = 20;
    localparam int TOTAL_SETS      = NUM_FIXED_SETS + NUM_REGION_SETS;

    localparam int VAL_W    = 64;
    localparam int ACT_W    = 2;
    localparam int SET_IN_W = 4;
    localparam int BKT_W    = 5;
    localparam int SHIFT_W  = 6;

    localparam int SET_AW    = (TOTAL_SETS > 1) ? $clog2(TOTAL_SETS) : 1;
    localparam int RGN_AW    = (NUM_REGION_SETS > 1) ? $clog2(NUM_REGION_SETS) : 1;
    localparam int BKT_DEPTH = TOTAL_SETS * NUM_BUCKETS;
    localparam int BKT_AW    = $clog2(BKT_DEPTH);

    localparam int GRP_W   = 8;
    localparam int NUM_GRP = VAL_W / GRP_W;
    localparam int POS_W   = $clog2(GRP_W);
    localparam int LOG_W   = $clog2(VAL_W);

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(6);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_SHIFT_IDX = '0;

    typedef enum logic [ACT_W-1:0] {
        ACT_RECORD,
        ACT_BEGIN,
        ACT_END,
        ACT_READ
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RGN_RD,
        S_RGN_DIFF,
        S_LOG_GRP,
        S_LOG_SEL,
        S_SET_RD,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic [VAL_W-1:0] cnt;
        logic [VAL_W-1:0] sum;
        logic [VAL_W-1:0] mn;
        logic [VAL_W-1:0] mx;
    } t_set_entry;

endpackage

/* design/latency_stats_histogram_top.sv */
// ----------------------------------------------------------------------------
// latency_stats_histogram_top
// Latency statistics for fixed sites and regions with log2 histograms.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the input stalls from acceptance until the
// result is placed in the output register. Reads and region begins go through
// S_SET_RD and S_UPDATE, records through S_LOG_GRP, S_LOG_SEL, S_SET_RD and
// S_UPDATE, region ends through S_RGN_RD and S_RGN_DIFF and then as records,
// and bad indexes straight to S_UPDATE, since memory reads are registered and
// a two-step leading-one search picks the bucket. A new item is taken while an
// earlier result still waits in the output register. The stores come out of
// reset cleared at once via per-entry valid flags; no clearing pass is needed.
module latency_stats_histogram_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lsh_pkg::ACT_W-1:0]     i_action,
    input  logic [lsh_pkg::SET_IN_W-1:0]  i_set_index,
    input  logic [lsh_pkg::VAL_W-1:0]     i_value,
    input  logic [lsh_pkg::BKT_W-1:0]     i_query_bucket,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_status,
    output logic [lsh_pkg::VAL_W-1:0]     o_sample_count,
    output logic [lsh_pkg::VAL_W-1:0]     o_sample_sum,
    output logic [lsh_pkg::VAL_W-1:0]     o_min_seen,
    output logic [lsh_pkg::VAL_W-1:0]     o_max_seen,
    output logic [lsh_pkg::BKT_W-1:0]     o_bucket_used,
    output logic [lsh_pkg::VAL_W-1:0]     o_bucket_total,
    output logic [lsh_pkg::VAL_W-1:0]     o_recorded_duration,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsh_pkg::PADDR_W-1:0]   paddr,
    input  logic [lsh_pkg::PDATA_W-1:0]   pwdata,
    output logic [lsh_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    import lsh_pkg::*;

    t_state r_state, n_state;

    logic [SHIFT_W-1:0]    r_shift;
    logic [TOTAL_SETS-1:0] r_set_vld;
    logic [NUM_REGION_SETS-1:0] r_rgn_vld;
    logic [BKT_DEPTH-1:0]  r_bkt_vld;
    logic                  r_out_valid;

    t_action               r_action;
    logic [SET_IN_W-1:0]   r_set;
    logic [VAL_W-1:0]      r_value;
    logic [VAL_W-1:0]      r_dur;
    logic [BKT_W-1:0]      r_bucket;
    logic                  r_ignore;
    logic [NUM_GRP-1:0]    r_grp_nz;
    logic [POS_W-1:0]      r_grp_pos [NUM_GRP];

    logic                  r_status;
    logic [VAL_W-1:0]      r_cnt_o, r_sum_o, r_min_o, r_max_o, r_btot_o, r_dur_o;
    logic [BKT_W-1:0]      r_bkt_o;

    logic                  accept;
    logic                  in_ignore;
    logic [BKT_W-1:0]      in_qbkt;
    logic                  commit;
    logic                  upd_record;
    logic                  rgn_we;
    logic                  cfg_wr;

    logic [SET_AW-1:0]     set_addr;
    logic [RGN_AW-1:0]     rgn_addr;
    logic [BKT_AW-1:0]     bkt_addr;
    t_set_entry            set_rdata, set_cur, set_nxt;
    logic [VAL_W-1:0]      rgn_rdata, rgn_cur;
    logic [VAL_W-1:0]      bkt_rdata, bkt_cur, bkt_nxt;

    logic [NUM_GRP-1:0]    grp_nz;
    logic [POS_W-1:0]      grp_pos [NUM_GRP];
    logic [BKT_W-1:0]      bkt_calc;

    // handshake and decode
    assign accept    = i_in_valid && !o_in_stall;
    assign in_ignore = (int'(i_set_index) >= TOTAL_SETS) ||
                       ((i_action inside {ACT_BEGIN, ACT_END}) &&
                        (int'(i_set_index) < NUM_FIXED_SETS));
    assign in_qbkt   = (int'(i_query_bucket) >= NUM_BUCKETS) ?
                       BKT_W'(NUM_BUCKETS - 1) : i_query_bucket;

    assign set_addr = SET_AW'(r_set);
    assign rgn_addr = RGN_AW'(int'(r_set) - NUM_FIXED_SETS);
    assign bkt_addr = BKT_AW'(r_set) * BKT_AW'(NUM_BUCKETS) + BKT_AW'(r_bucket);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_ignore) begin
                        n_state = S_UPDATE;
                    end else begin
                        case (t_action'(i_action))
                            ACT_RECORD: n_state = S_LOG_GRP;
                            ACT_END:    n_state = S_RGN_RD;
                            default:    n_state = S_SET_RD;
                        endcase
                    end
                end
            end
            S_RGN_RD:   n_state = S_RGN_DIFF;
            S_RGN_DIFF: n_state = S_LOG_GRP;
            S_LOG_GRP:  n_state = S_LOG_SEL;
            S_LOG_SEL:  n_state = S_SET_RD;
            S_SET_RD:   n_state = S_UPDATE;
            S_UPDATE: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        commit     = (r_state == S_UPDATE) && (!r_out_valid || !i_out_stall);
        upd_record = commit && !r_ignore && (r_action inside {ACT_RECORD, ACT_END});
        rgn_we     = commit && !r_ignore && (r_action == ACT_BEGIN);
    end

    // leading-one search, first step: per byte
    always_comb begin
        logic [GRP_W-1:0] grp_byte;
        for (int g = 0; g < NUM_GRP; g++) begin
            grp_byte   = r_dur[g*GRP_W +: GRP_W];
            grp_nz[g]  = |grp_byte;
            grp_pos[g] = '0;
            for (int k = 0; k < GRP_W; k++) begin
                if (grp_byte[k]) begin
                    grp_pos[g] = POS_W'(k);
                end
            end
        end
    end

    // leading-one search, second step: pick the byte and map to a bucket
    always_comb begin
        logic [LOG_W-1:0] lg;
        logic [LOG_W:0]   raw;
        lg = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            if (r_grp_nz[g]) begin
                lg = LOG_W'(g * GRP_W) + LOG_W'(r_grp_pos[g]);
            end
        end
        raw = (LOG_W+1)'(lg) + (LOG_W+1)'(1) - (LOG_W+1)'(r_shift);
        if (!(|r_grp_nz) || ((LOG_W+1)'(lg) < (LOG_W+1)'(r_shift))) begin
            bkt_calc = '0;
        end else if (int'(raw) >= NUM_BUCKETS) begin
            bkt_calc = BKT_W'(NUM_BUCKETS - 1);
        end else begin
            bkt_calc = BKT_W'(raw);
        end
    end

    // read-modify-write of the set and bucket entries
    always_comb begin
        if (r_set_vld[set_addr]) begin
            set_cur = set_rdata;
        end else begin
            set_cur.cnt = '0;
            set_cur.sum = '0;
            set_cur.mn  = '1;
            set_cur.mx  = '0;
        end
        bkt_cur = r_bkt_vld[bkt_addr] ? bkt_rdata : '0;
        rgn_cur = r_rgn_vld[rgn_addr] ? rgn_rdata : '0;
        set_nxt = set_cur;
        bkt_nxt = bkt_cur;
        if (r_action inside {ACT_RECORD, ACT_END}) begin
            set_nxt.mn  = (r_dur < set_cur.mn) ? r_dur : set_cur.mn;
            set_nxt.mx  = (r_dur > set_cur.mx) ? r_dur : set_cur.mx;
            set_nxt.sum = set_cur.sum + r_dur;
            set_nxt.cnt = set_cur.cnt + VAL_W'(1);
            bkt_nxt     = bkt_cur + VAL_W'(1);
        end
    end

    lsh_ram #(
        .WIDTH ($bits(t_set_entry)),
        .DEPTH (TOTAL_SETS)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (upd_record),
        .i_waddr (set_addr),
        .i_wdata (set_nxt),
        .i_raddr (set_addr),
        .o_rdata (set_rdata)
    );

    lsh_ram #(
        .WIDTH (VAL_W),
        .DEPTH (BKT_DEPTH)
    ) u_bkt_ram (
        .i_clk   (i_clk),
        .i_we    (upd_record),
        .i_waddr (bkt_addr),
        .i_wdata (bkt_nxt),
        .i_raddr (bkt_addr),
        .o_rdata (bkt_rdata)
    );

    lsh_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NUM_REGION_SETS)
    ) u_rgn_ram (
        .i_clk   (i_clk),
        .i_we    (rgn_we),
        .i_waddr (rgn_addr),
        .i_wdata (r_value),
        .i_raddr (rgn_addr),
        .o_rdata (rgn_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_shift     <= SHIFT_RESET;
            r_set_vld   <= '0;
            r_rgn_vld   <= '0;
            r_bkt_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr && paddr[PADDR_W-1:2] == REG_SHIFT_IDX) begin
                r_shift <= pwdata[SHIFT_W-1:0];
            end
            if (upd_record) begin
                r_set_vld[set_addr] <= 1'b1;
                r_bkt_vld[bkt_addr] <= 1'b1;
            end
            if (rgn_we) begin
                r_rgn_vld[rgn_addr] <= 1'b1;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= t_action'(i_action);
            r_set    <= i_set_index;
            r_value  <= i_value;
            r_ignore <= in_ignore;
            r_dur    <= (i_action == ACT_RECORD) ? i_value : '0;
            r_bucket <= (i_action == ACT_READ) ? in_qbkt : '0;
        end
        if (r_state == S_RGN_DIFF) begin
            r_dur <= r_value - rgn_cur;
        end
        if (r_state == S_LOG_GRP) begin
            r_grp_nz <= grp_nz;
            for (int g = 0; g < NUM_GRP; g++) begin
                r_grp_pos[g] <= grp_pos[g];
            end
        end
        if (r_state == S_LOG_SEL) begin
            r_bucket <= bkt_calc;
        end
        if (commit) begin
            if (r_ignore) begin
                r_status  <= 1'b1;
                r_cnt_o   <= '0;
                r_sum_o   <= '0;
                r_min_o   <= '0;
                r_max_o   <= '0;
                r_bkt_o   <= '0;
                r_btot_o  <= '0;
                r_dur_o   <= '0;
            end else begin
                r_status  <= 1'b0;
                r_cnt_o   <= set_nxt.cnt;
                r_sum_o   <= set_nxt.sum;
                r_min_o   <= (set_nxt.cnt != '0) ? set_nxt.mn : '0;
                r_max_o   <= (set_nxt.cnt != '0) ? set_nxt.mx : '0;
                r_bkt_o   <= r_bucket;
                r_btot_o  <= (r_action == ACT_BEGIN) ? '0 : bkt_nxt;
                r_dur_o   <= r_dur;
            end
        end
    end

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1:2] == REG_SHIFT_IDX) ? PDATA_W'(r_shift) : '0;

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_status;
    assign o_sample_count      = r_cnt_o;
    assign o_sample_sum        = r_sum_o;
    assign o_min_seen          = r_min_o;
    assign o_max_seen          = r_max_o;
    assign o_bucket_used       = r_bkt_o;
    assign o_bucket_total      = r_btot_o;
    assign o_recorded_duration = r_dur_o;

endmodule

/* design/lsh_ram.sv */
// ----------------------------------------------------------------------------
// lsh_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lsh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* verif/latency_stats_histogram_top_tb.sv */
// ----------------------------------------------------------------------------
// latency_stats_histogram_top_tb
// Self-checking bench for the latency statistics histogram block. A directed
// table covers reset state, bad indexes, region actions on fixed sites,
// bucket edges and wrapping, then random items run under several bucket base
// shifts. Fixed rows are checked against fixed values, the rest against an
// in-bench model of the per-set min, max, sum, count and log2 histogram.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module latency_stats_histogram_top_tb;
    import lsh_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RAND_PER_PHASE = 192;
    localparam int NUM_PHASES     = 6;
    localparam int RANDOM_SHIFT   = -1;
    localparam int PHASE_SHIFT [NUM_PHASES] = '{0, 40, 63, RANDOM_SHIFT, RANDOM_SHIFT, 6};

    typedef struct packed {
        t_action               act;
        logic [SET_IN_W-1:0]   set_index;
        logic [VAL_W-1:0]      value;
        logic [BKT_W-1:0]      query_bucket;
    } t_stats_req;

    typedef struct packed {
        logic                  status;
        logic [VAL_W-1:0]      sample_count;
        logic [VAL_W-1:0]      sample_sum;
        logic [VAL_W-1:0]      min_seen;
        logic [VAL_W-1:0]      max_seen;
        logic [BKT_W-1:0]      bucket_used;
        logic [VAL_W-1:0]      bucket_total;
        logic [VAL_W-1:0]      recorded_duration;
    } t_stats_result;

    typedef struct packed {
        t_stats_req            req;
        logic                  fixed_exp;
        logic                  exp_status;
        logic [BKT_W-1:0]      exp_bucket;
    } t_dir_row;

    localparam int DIR_LEN = 25;
    localparam t_dir_row DIR_ROWS [DIR_LEN] = '{
        '{'{ACT_READ,   4'd0,  64'd0,                  5'd0},  1'b1, 1'b0, 5'd0},
        '{'{ACT_READ,   4'd11, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31}, 1'b1, 1'b0, 5'd19},
        '{'{ACT_RECORD, 4'd12, 64'd5,                  5'd0},  1'b1, 1'b1, 5'd0},
        '{'{ACT_READ,   4'd15, 64'd0,                  5'd3},  1'b1, 1'b1, 5'd0},
        '{'{ACT_BEGIN,  4'd0,  64'd77,                 5'd0},  1'b1, 1'b1, 5'd0},
        '{'{ACT_END,    4'd3,  64'd900,                5'd0},  1'b1, 1'b1, 5'd0},
        '{'{ACT_BEGIN,  4'd13, 64'd1,                  5'd0},  1'b1, 1'b1, 5'd0},
        '{'{ACT_END,    4'd14, 64'd2,                  5'd0},  1'b1, 1'b1, 5'd0},
        '{'{ACT_RECORD, 4'd0,  64'd0,                  5'd0},  1'b0, 1'b0, 5'd0},
        '{'{ACT_RECORD, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF, 5'd0},  1'b0, 1'b0, 5'd0},
        '{'{ACT_RECORD, 4'd0,  64'd63,                 5'd0},  1'b0, 1'b0, 5'd0},
        '{'{ACT_RECORD, 4'd0,  64'd64,                 5'd0},  1'b0, 1'b0, 5'd0},
        '{'{ACT_RECORD, 4'd1,  64'h0000_0000_0080_0000, 5'd0},  1'b0, 1'b0, 5'd0},
        '{'{ACT_RECORD, 4'd1,  64'h0000_0000_0100_0000, 5'd0},  1'b0, 1'b0, 5'd0},
        '{'{ACT_RECORD, 4'd4,  64'd100,                5'd0},  1'b0, 1'b0, 5'd0},
        '{'{ACT_END,    4'd5,  64'd1000,               5'd0},  1'b0, 1'b0, 5'd0},
        '{'{ACT_BEGIN,  4'd6,  64'hFFFF_FFFF_FFFF_FF00, 5'd0},  1'b0, 1'b0, 5'd0},
        '{'{ACT_END,    4'd6,  64'h10,                 5'd0},  1'b0, 1'b0, 5'd0},
        '{'{ACT_BEGIN,  4'd11, 64'd0,                  5'd0},  1'b0, 1'b0, 5'd0},
        '{'{ACT_END,    4'd11, 64'd0,                  5'd0},  1'b0, 1'b0, 5'd0},
        '{'{ACT_RECORD, 4'd2,  64'h8000_0000_0000_0000, 5'd0},  1'b0, 1'b0, 5'd0},
        '{'{ACT_RECORD, 4'd2,  64'hFFFF_FFFF_FFFF_FFFF, 5'd0},  1'b0, 1'b0, 5'd0},
        '{'{ACT_READ,   4'd0,  64'd0,                  5'd19}, 1'b0, 1'b0, 5'd0},
        '{'{ACT_READ,   4'd6,  64'd0,                  5'd20}, 1'b0, 1'b0, 5'd0},
        '{'{ACT_READ,   4'd2,  64'd0,                  5'd0},  1'b0, 1'b0, 5'd0}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [ACT_W-1:0]      i_action;
    logic [SET_IN_W-1:0]   i_set_index;
    logic [VAL_W-1:0]      i_value;
    logic [BKT_W-1:0]      i_query_bucket;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_status;
    logic [VAL_W-1:0]      o_sample_count;
    logic [VAL_W-1:0]      o_sample_sum;
    logic [VAL_W-1:0]      o_min_seen;
    logic [VAL_W-1:0]      o_max_seen;
    logic [BKT_W-1:0]      o_bucket_used;
    logic [VAL_W-1:0]      o_bucket_total;
    logic [VAL_W-1:0]      o_recorded_duration;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    logic [VAL_W-1:0]      acc_min   [TOTAL_SETS];
    logic [VAL_W-1:0]      acc_max   [TOTAL_SETS];
    logic [VAL_W-1:0]      acc_sum   [TOTAL_SETS];
    logic [VAL_W-1:0]      acc_count [TOTAL_SETS];
    logic [VAL_W-1:0]      acc_hist  [TOTAL_SETS][NUM_BUCKETS];
    logic [VAL_W-1:0]      region_stamp [NUM_REGION_SETS];
    logic [SHIFT_W-1:0]    bucket_shift;

    t_stats_result         pending_stats [$];
    int                    mismatch_count;
    bit                    idle_en;
    int                    out_stall_left;

    latency_stats_histogram_top uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_stats_result apply_latency_item(input t_stats_req req);
        t_stats_result res;
        logic [VAL_W-1:0] dur;
        int s;
        int b;
        int msb;
        res = '0;
        s = int'(req.set_index);
        if (s >= TOTAL_SETS) begin
            res.status = 1'b1;
            return res;
        end
        if ((req.act inside {ACT_BEGIN, ACT_END}) && s < NUM_FIXED_SETS) begin
            res.status = 1'b1;
            return res;
        end
        dur = '0;
        b = 0;
        if (req.act == ACT_BEGIN) begin
            region_stamp[s - NUM_FIXED_SETS] = req.value;
        end else if (req.act == ACT_READ) begin
            b = (int'(req.query_bucket) >= NUM_BUCKETS) ? NUM_BUCKETS - 1
                                                        : int'(req.query_bucket);
        end else begin
            dur = (req.act == ACT_RECORD) ? req.value
                                          : req.value - region_stamp[s - NUM_FIXED_SETS];
            if (dur >= (64'd1 << bucket_shift)) begin
                msb = 0;
                for (int i = 0; i < VAL_W; i++) begin
                    if (dur[i]) msb = i;
                end
                b = msb - int'(bucket_shift) + 1;
                if (b >= NUM_BUCKETS) b = NUM_BUCKETS - 1;
            end
            if (dur < acc_min[s]) acc_min[s] = dur;
            if (dur > acc_max[s]) acc_max[s] = dur;
            acc_sum[s]     = acc_sum[s] + dur;
            acc_count[s]   = acc_count[s] + 64'd1;
            acc_hist[s][b] = acc_hist[s][b] + 64'd1;
        end
        res.sample_count      = acc_count[s];
        res.sample_sum        = acc_sum[s];
        res.min_seen          = (acc_count[s] != 0) ? acc_min[s] : '0;
        res.max_seen          = (acc_count[s] != 0) ? acc_max[s] : '0;
        res.bucket_used       = BKT_W'(b);
        res.bucket_total      = (req.act == ACT_BEGIN) ? '0 : acc_hist[s][b];
        res.recorded_duration = dur;
        return res;
    endfunction

    function automatic t_stats_req make_stats_request();
        t_stats_req req;
        logic [VAL_W-1:0] wide;
        int roll;
        int r;
        roll = $urandom_range(0, 99);
        r = $urandom_range(0, NUM_REGION_SETS - 1);
        wide = {$urandom, $urandom};
        req.act = t_action'($urandom_range(0, 3));
        req.set_index = SET_IN_W'($urandom_range(0, TOTAL_SETS - 1));
        req.value = {$urandom, $urandom};
        req.query_bucket = BKT_W'($urandom_range(0, 31));
        if (roll < 6) begin
            req.set_index = SET_IN_W'($urandom_range(TOTAL_SETS, 15));
        end else if (roll < 10) begin
            req.act = ($urandom_range(0, 1) != 0) ? ACT_BEGIN : ACT_END;
            req.set_index = SET_IN_W'($urandom_range(0, NUM_FIXED_SETS - 1));
        end else if (roll < 35) begin
            req.act = ACT_RECORD;
            req.value = wide >> $urandom_range(0, 63);
        end else if (roll < 55) begin
            req.act = ACT_BEGIN;
            req.set_index = SET_IN_W'(NUM_FIXED_SETS + r);
        end else if (roll < 82) begin
            req.act = ACT_END;
            req.set_index = SET_IN_W'(NUM_FIXED_SETS + r);
            req.value = region_stamp[r] + (wide >> $urandom_range(0, 63));
        end else if (roll < 86) begin
            req.act = ACT_END;
            req.set_index = SET_IN_W'(NUM_FIXED_SETS + r);
        end else begin
            req.act = ACT_READ;
        end
        return req;
    endfunction

    task automatic issue_item(input t_stats_req req, input logic use_fixed,
                              input t_stats_result fixed_res);
        t_stats_result want;
        int gap;
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 99) < 20) begin
            gap = $urandom_range(1, 9);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_action       = req.act;
        i_set_index    = req.set_index;
        i_value        = req.value;
        i_query_bucket = req.query_bucket;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        want = apply_latency_item(req);
        pending_stats.push_back(use_fixed ? fixed_res : want);
    endtask

    task automatic write_bucket_shift(input logic [SHIFT_W-1:0] val);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {REG_SHIFT_IDX, 2'b00};
        pwdata  = PDATA_W'(val);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        bucket_shift = val;
        @(negedge i_clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== PDATA_W'(val)) begin
            $error("bucket_base_shift: expected %0h, actual %0h", val, prdata);
            mismatch_count++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_stats_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_stats.size() == 0) begin
                $error("result with no item outstanding");
                mismatch_count++;
            end else begin
                want = pending_stats.pop_front();
                check_field("status", VAL_W'(want.status), VAL_W'(o_status));
                check_field("sample_count", want.sample_count, o_sample_count);
                check_field("sample_sum", want.sample_sum, o_sample_sum);
                check_field("min_seen", want.min_seen, o_min_seen);
                check_field("max_seen", want.max_seen, o_max_seen);
                check_field("bucket_used", VAL_W'(want.bucket_used), VAL_W'(o_bucket_used));
                check_field("bucket_total", want.bucket_total, o_bucket_total);
                check_field("recorded_duration", want.recorded_duration, o_recorded_duration);
            end
        end
    end

    // output side back-pressure
    initial begin
        i_out_stall = 1'b0;
        out_stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (out_stall_left > 0) begin
                out_stall_left--;
            end else if (idle_en && $urandom_range(0, 99) < 12) begin
                out_stall_left = $urandom_range(1, 9);
            end
            i_out_stall = (out_stall_left > 0);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("latency_stats_histogram_top_tb: errors");
        $finish;
    end

    initial begin
        t_stats_result fixed_res;
        logic [SHIFT_W-1:0] next_shift;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_action       = ACT_RECORD;
        i_set_index    = '0;
        i_value        = '0;
        i_query_bucket = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        idle_en        = 1'b1;
        mismatch_count = 0;
        bucket_shift   = SHIFT_RESET;
        for (int s = 0; s < TOTAL_SETS; s++) begin
            acc_min[s]   = '1;
            acc_max[s]   = '0;
            acc_sum[s]   = '0;
            acc_count[s] = '0;
            for (int b = 0; b < NUM_BUCKETS; b++) acc_hist[s][b] = '0;
        end
        for (int r = 0; r < NUM_REGION_SETS; r++) region_stamp[r] = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int k = 0; k < DIR_LEN; k++) begin
            fixed_res = '0;
            fixed_res.status = DIR_ROWS[k].exp_status;
            fixed_res.bucket_used = DIR_ROWS[k].exp_bucket;
            issue_item(DIR_ROWS[k].req, DIR_ROWS[k].fixed_exp, fixed_res);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (PHASE_SHIFT[ph] == RANDOM_SHIFT) begin
                next_shift = SHIFT_W'($urandom_range(0, 63));
            end else begin
                next_shift = SHIFT_W'(PHASE_SHIFT[ph]);
            end
            write_bucket_shift(next_shift);
            if (ph == NUM_PHASES - 1) idle_en = 1'b0;
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                issue_item(make_stats_request(), 1'b0, '0);
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("latency_stats_histogram_top_tb: clean");
        end else begin
            $display("latency_stats_histogram_top_tb: errors");
        end
        $finish;
    end

endmodule
